/* hw/rtl/rbro_pkg.sv */
// ----------------------------------------------------------------------------
// rbro_pkg
// shared types, widths and codes of the rectangle blitter raster-op block
// ----------------------------------------------------------------------------
`default_nettype none

package rbro_pkg;

  // default datapath widths
  localparam int PIXEL_BITS  = 16;
  localparam int OFFSET_BITS = 26;

  // coordinate geometry is fixed by the register map
  localparam int COORD_BITS  = 12;
  localparam int SIZE_BITS   = COORD_BITS + 1;
  localparam int STRIDE_BITS = COORD_BITS + 2;
  localparam int SIZE_MAX    = 1 << COORD_BITS;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = STRIDE_BITS;

  localparam int OPCODE_BITS = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SOURCE_X      = 3'd0,
    REG_SOURCE_Y      = 3'd1,
    REG_TARGET_X      = 3'd2,
    REG_TARGET_Y      = 3'd3,
    REG_RECT_WIDTH    = 3'd4,
    REG_RECT_HEIGHT   = 3'd5,
    REG_SOURCE_STRIDE = 3'd6,
    REG_TARGET_STRIDE = 3'd7
  } cfg_reg_t;

  typedef enum logic [OPCODE_BITS-1:0] {
    ROP_ZERO     = 4'd0,
    ROP_AND      = 4'd1,
    ROP_AND_NOTD = 4'd2,
    ROP_SRC      = 4'd3,
    ROP_NOTS_AND = 4'd4,
    ROP_DST      = 4'd5,
    ROP_XOR      = 4'd6,
    ROP_OR       = 4'd7,
    ROP_NOR      = 4'd8,
    ROP_XNOR     = 4'd9,
    ROP_NOTD     = 4'd10,
    ROP_OR_NOTD  = 4'd11,
    ROP_NOTS     = 4'd12,
    ROP_NOTS_OR  = 4'd13,
    ROP_NAND     = 4'd14,
    ROP_ONE      = 4'd15
  } rop_t;

  // register file contents
  typedef struct packed {
    logic [COORD_BITS-1:0]  source_x;
    logic [COORD_BITS-1:0]  source_y;
    logic [COORD_BITS-1:0]  target_x;
    logic [COORD_BITS-1:0]  target_y;
    logic [SIZE_BITS-1:0]   rect_width;
    logic [SIZE_BITS-1:0]   rect_height;
    logic [STRIDE_BITS-1:0] source_stride;
    logic [STRIDE_BITS-1:0] target_stride;
  } cfg_t;

  // absolute walk position of one pixel, surface coordinates
  typedef struct packed {
    logic [SIZE_BITS-1:0] src_row;
    logic [SIZE_BITS-1:0] src_col;
    logic [SIZE_BITS-1:0] dst_row;
    logic [SIZE_BITS-1:0] dst_col;
    logic                 last;
  } walk_pos_t;

endpackage

`default_nettype wire

/* hw/rtl/rbro_in_if.sv */
// ----------------------------------------------------------------------------
// rbro_in_if
// input channel: raster-op code, source pixel and destination pixel
// ----------------------------------------------------------------------------
`default_nettype none

interface rbro_in_if #(
  parameter int PIXEL_BITS = rbro_pkg::PIXEL_BITS
) ();
  logic                             valid;
  logic                             ready;
  logic [rbro_pkg::OPCODE_BITS-1:0] opcode;
  logic [PIXEL_BITS-1:0]            src_pixel;
  logic [PIXEL_BITS-1:0]            dst_pixel;

  modport source (output valid, output opcode, output src_pixel, output dst_pixel,
                  input ready);
  modport sink   (input valid, input opcode, input src_pixel, input dst_pixel,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/rbro_out_if.sv */
// ----------------------------------------------------------------------------
// rbro_out_if
// result channel: combined pixel, pixel offsets and last-pixel flag
// ----------------------------------------------------------------------------
`default_nettype none

interface rbro_out_if #(
  parameter int PIXEL_BITS  = rbro_pkg::PIXEL_BITS,
  parameter int OFFSET_BITS = rbro_pkg::OFFSET_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic [PIXEL_BITS-1:0]  out_pixel;
  logic [OFFSET_BITS-1:0] src_offset;
  logic [OFFSET_BITS-1:0] dst_offset;
  logic                   last_pixel;

  modport source (output valid, output out_pixel, output src_offset,
                  output dst_offset, output last_pixel, input ready);
  modport sink   (input valid, input out_pixel, input src_offset,
                  input dst_offset, input last_pixel, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rbro_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rbro_cfg_regs
// write-only register file for rectangle geometry and strides
// ----------------------------------------------------------------------------
`default_nettype none

module rbro_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [rbro_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [rbro_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output rbro_pkg::cfg_t                           cfg
);

  rbro_pkg::cfg_t cfg_r;
  rbro_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (rbro_pkg::cfg_reg_t'(cfg_index))
        rbro_pkg::REG_SOURCE_X:
          cfg_nxt.source_x = cfg_data[rbro_pkg::COORD_BITS-1:0];
        rbro_pkg::REG_SOURCE_Y:
          cfg_nxt.source_y = cfg_data[rbro_pkg::COORD_BITS-1:0];
        rbro_pkg::REG_TARGET_X:
          cfg_nxt.target_x = cfg_data[rbro_pkg::COORD_BITS-1:0];
        rbro_pkg::REG_TARGET_Y:
          cfg_nxt.target_y = cfg_data[rbro_pkg::COORD_BITS-1:0];
        rbro_pkg::REG_RECT_WIDTH:
          cfg_nxt.rect_width = cfg_data[rbro_pkg::SIZE_BITS-1:0];
        rbro_pkg::REG_RECT_HEIGHT:
          cfg_nxt.rect_height = cfg_data[rbro_pkg::SIZE_BITS-1:0];
        rbro_pkg::REG_SOURCE_STRIDE:
          cfg_nxt.source_stride = cfg_data[rbro_pkg::STRIDE_BITS-1:0];
        rbro_pkg::REG_TARGET_STRIDE:
          cfg_nxt.target_stride = cfg_data[rbro_pkg::STRIDE_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_x      <= '0;
      cfg_r.source_y      <= '0;
      cfg_r.target_x      <= '0;
      cfg_r.target_y      <= '0;
      cfg_r.rect_width    <= rbro_pkg::SIZE_BITS'(1);
      cfg_r.rect_height   <= rbro_pkg::SIZE_BITS'(1);
      cfg_r.source_stride <= rbro_pkg::STRIDE_BITS'(1);
      cfg_r.target_stride <= rbro_pkg::STRIDE_BITS'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* hw/rtl/rbro_walk.sv */
// ----------------------------------------------------------------------------
// rbro_walk
// column/row counters, overlap-safe walk direction and position register
// ----------------------------------------------------------------------------
`default_nettype none

module rbro_walk (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rbro_pkg::cfg_t cfg,
  input  wire logic      step,     // an item is accepted this cycle
  output rbro_pkg::walk_pos_t pos
);

  localparam int CB = rbro_pkg::COORD_BITS;
  localparam int SB = rbro_pkg::SIZE_BITS;

  logic [CB-1:0] col_cnt_r, col_cnt_nxt;
  logic [CB-1:0] row_cnt_r, row_cnt_nxt;
  rbro_pkg::walk_pos_t pos_r, pos_nxt;

  logic [SB-1:0] w, h;
  logic [CB-1:0] w_m1, h_m1, cc, rc, row, col;
  logic          rows_up, cols_back, row_end;

  // zero acts as one, oversize acts as the maximum
  function automatic logic [SB-1:0] clamp_size(input logic [SB-1:0] v);
    logic [SB-1:0] r;
    if (v == '0) begin
      r = SB'(1);
    end else if (v > SB'(rbro_pkg::SIZE_MAX)) begin
      r = SB'(rbro_pkg::SIZE_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    w    = clamp_size(cfg.rect_width);
    h    = clamp_size(cfg.rect_height);
    w_m1 = CB'(w - SB'(1));
    h_m1 = CB'(h - SB'(1));
    cc   = ({1'b0, col_cnt_r} >= w) ? w_m1 : col_cnt_r;
    rc   = ({1'b0, row_cnt_r} >= h) ? h_m1 : row_cnt_r;

    rows_up   = cfg.source_y < cfg.target_y;
    cols_back = (cfg.source_y == cfg.target_y) && (cfg.source_x < cfg.target_x);
    row       = rows_up ? (h_m1 - rc) : rc;
    col       = cols_back ? (w_m1 - cc) : cc;
    row_end   = cc == w_m1;

    pos_nxt.src_row = {1'b0, cfg.source_y} + {1'b0, row};
    pos_nxt.src_col = {1'b0, cfg.source_x} + {1'b0, col};
    pos_nxt.dst_row = {1'b0, cfg.target_y} + {1'b0, row};
    pos_nxt.dst_col = {1'b0, cfg.target_x} + {1'b0, col};
    pos_nxt.last    = row_end && (rc == h_m1);

    if (pos_nxt.last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (row_end) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = rc + CB'(1);
    end else begin
      col_cnt_nxt = cc + CB'(1);
      row_cnt_nxt = rc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (step) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

  // the final pixel sends both counters back to the start
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && pos_nxt.last |=> (col_cnt_r == '0) && (row_cnt_r == '0))
    else $error("counters not cleared after last pixel");

  // inside a row only the column counter moves
  a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step && !row_end |=> (col_cnt_r == $past(cc) + CB'(1)) && (row_cnt_r == $past(rc)))
    else $error("column step lost or row counter moved mid-row");

endmodule

`default_nettype wire

/* hw/rtl/rbro_datapath.sv */
// ----------------------------------------------------------------------------
// rbro_datapath
// raster-op logic and offset multiply-add into the result register
// ----------------------------------------------------------------------------
`default_nettype none

module rbro_datapath #(
  parameter int PIXEL_BITS  = rbro_pkg::PIXEL_BITS,
  parameter int OFFSET_BITS = rbro_pkg::OFFSET_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             load,
  input  wire rbro_pkg::cfg_t                   cfg,
  input  wire rbro_pkg::walk_pos_t              pos,
  input  wire logic [rbro_pkg::OPCODE_BITS-1:0] opcode,
  input  wire logic [PIXEL_BITS-1:0]            src_pixel,
  input  wire logic [PIXEL_BITS-1:0]            dst_pixel,
  output logic      [PIXEL_BITS-1:0]            out_pixel,
  output logic      [OFFSET_BITS-1:0]           src_offset,
  output logic      [OFFSET_BITS-1:0]           dst_offset,
  output logic                                  last_pixel
);

  localparam int PROD_BITS = rbro_pkg::SIZE_BITS + rbro_pkg::STRIDE_BITS;
  localparam int SUM_BITS  = (OFFSET_BITS > PROD_BITS + 1) ? OFFSET_BITS : PROD_BITS + 1;

  logic [PIXEL_BITS-1:0]  pix_nxt, pix_r;
  logic [PROD_BITS-1:0]   src_prod, dst_prod;
  logic [SUM_BITS-1:0]    src_sum, dst_sum;
  logic [OFFSET_BITS-1:0] src_off_r, dst_off_r;
  logic                   last_r;

  always_comb begin
    case (rbro_pkg::rop_t'(opcode))
      rbro_pkg::ROP_ZERO:     pix_nxt = '0;
      rbro_pkg::ROP_AND:      pix_nxt = src_pixel & dst_pixel;
      rbro_pkg::ROP_AND_NOTD: pix_nxt = src_pixel & ~dst_pixel;
      rbro_pkg::ROP_SRC:      pix_nxt = src_pixel;
      rbro_pkg::ROP_NOTS_AND: pix_nxt = ~src_pixel & dst_pixel;
      rbro_pkg::ROP_DST:      pix_nxt = dst_pixel;
      rbro_pkg::ROP_XOR:      pix_nxt = src_pixel ^ dst_pixel;
      rbro_pkg::ROP_OR:       pix_nxt = src_pixel | dst_pixel;
      rbro_pkg::ROP_NOR:      pix_nxt = ~(src_pixel | dst_pixel);
      rbro_pkg::ROP_XNOR:     pix_nxt = ~(src_pixel ^ dst_pixel);
      rbro_pkg::ROP_NOTD:     pix_nxt = ~dst_pixel;
      rbro_pkg::ROP_OR_NOTD:  pix_nxt = src_pixel | ~dst_pixel;
      rbro_pkg::ROP_NOTS:     pix_nxt = ~src_pixel;
      rbro_pkg::ROP_NOTS_OR:  pix_nxt = ~src_pixel | dst_pixel;
      rbro_pkg::ROP_NAND:     pix_nxt = ~(src_pixel & dst_pixel);
      rbro_pkg::ROP_ONE:      pix_nxt = '1;
      default:                pix_nxt = '1;
    endcase
  end

  // row times stride plus column, wrapped to the offset width
  always_comb begin
    src_prod = PROD_BITS'(pos.src_row) * PROD_BITS'(cfg.source_stride);
    dst_prod = PROD_BITS'(pos.dst_row) * PROD_BITS'(cfg.target_stride);
    src_sum  = SUM_BITS'(src_prod) + SUM_BITS'(pos.src_col);
    dst_sum  = SUM_BITS'(dst_prod) + SUM_BITS'(pos.dst_col);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r     <= pix_nxt;
      src_off_r <= src_sum[OFFSET_BITS-1:0];
      dst_off_r <= dst_sum[OFFSET_BITS-1:0];
      last_r    <= pos.last;
    end
  end

  assign out_pixel  = pix_r;
  assign src_offset = src_off_r;
  assign dst_offset = dst_off_r;
  assign last_pixel = last_r;

endmodule

`default_nettype wire

/* hw/rtl/rect_blit_raster_op_16bit.sv */
// ----------------------------------------------------------------------------
// rect_blit_raster_op_16bit
// walk order and raster-op datapath of a 16-bit rectangle blitter
// ----------------------------------------------------------------------------
// Streams one pixel per clock. Each item on in_chan carries a raster-op code
// and the source and destination pixels at the current walk position; each
// result on out_chan carries the combined pixel, the source and destination
// offsets (row * stride + column, wrapped to OFFSET_BITS) and a last-pixel
// flag. An item passes two register stages: the walk counters and position
// register form the first, loaded by the clock edge that accepts the item;
// the raster-op and the stride multiply-add feed the result register in the
// second, loaded when that stage advances. Both stages hand over in the same
// cycle, so one item is accepted every clock as long as the result side keeps
// up. The walk is overlap safe: rows run bottom to top when the source lies
// above the destination, columns run right to left on the same row with the
// source to the left, otherwise the walk is top-down, left to right. After the
// last pixel the walk restarts. Registers must be written only while the block
// is idle, which the block does not enforce; they are not read back.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_blit_raster_op_16bit #(
  parameter int PIXEL_BITS  = rbro_pkg::PIXEL_BITS,
  parameter int OFFSET_BITS = rbro_pkg::OFFSET_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  rbro_in_if.sink                                  in_chan,
  rbro_out_if.source                               out_chan,
  input  wire logic                                cfg_we,
  input  wire logic [rbro_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [rbro_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  rbro_pkg::cfg_t      cfg;
  rbro_pkg::walk_pos_t pos;

  // stage valid flags: position stage and result stage
  logic pos_vld_r, pos_vld_nxt;
  logic res_vld_r, res_vld_nxt;
  logic res_adv, pos_adv, in_acc;

  // payload held alongside the walk position
  logic [rbro_pkg::OPCODE_BITS-1:0] opcode_r;
  logic [PIXEL_BITS-1:0]            src_pix_r;
  logic [PIXEL_BITS-1:0]            dst_pix_r;

  // each stage moves when the one after it is empty or draining
  assign res_adv = !res_vld_r || out_chan.ready;
  assign pos_adv = !pos_vld_r || res_adv;
  assign in_acc  = in_chan.valid && pos_adv;

  assign in_chan.ready = pos_adv;

  always_comb begin
    pos_vld_nxt = pos_vld_r;
    res_vld_nxt = res_vld_r;
    if (pos_adv) begin
      pos_vld_nxt = in_chan.valid;
    end
    if (res_adv) begin
      res_vld_nxt = pos_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      pos_vld_r <= pos_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      opcode_r  <= in_chan.opcode;
      src_pix_r <= in_chan.src_pixel;
      dst_pix_r <= in_chan.dst_pixel;
    end
  end

  rbro_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // counters step only on an accepted item
  rbro_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (in_acc),
    .pos   (pos)
  );

  rbro_datapath #(
    .PIXEL_BITS  (PIXEL_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk        (clk),
    .load       (res_adv && pos_vld_r),
    .cfg        (cfg),
    .pos        (pos),
    .opcode     (opcode_r),
    .src_pixel  (src_pix_r),
    .dst_pixel  (dst_pix_r),
    .out_pixel  (out_chan.out_pixel),
    .src_offset (out_chan.src_offset),
    .dst_offset (out_chan.dst_offset),
    .last_pixel (out_chan.last_pixel)
  );

  assign out_chan.valid = res_vld_r;

  // an empty result stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !res_vld_r |-> in_chan.ready)
    else $error("input stalled with empty result stage");

  // a stalled position stage keeps its item
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pos_vld_r && !res_adv |=> pos_vld_r)
    else $error("position stage item dropped under stall");

  // a new result only appears behind a filled position stage
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_vld_r) |-> $past(pos_vld_r))
    else $error("result appeared without an item in flight");

endmodule

`default_nettype wire
